### sv/hsl240_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hsl240_pkg
// Shared types, constants and constant dividers for the 240-scale HSL to
// RGB converter.
// ---------------------------------------------------------------------------
package hsl240_pkg;

    localparam logic [7:0]  SCALE_MAX   = 8'd240;
    localparam logic [7:0]  HALF_SCALE  = 8'd120;
    localparam logic [7:0]  HUE_THIRD   = 8'd80;
    localparam logic [7:0]  HUE_COMP    = 8'd160;   // 240 - 80
    localparam logic [7:0]  RISE_END    = 8'd40;
    localparam logic [7:0]  FLAT_END    = 8'd120;
    localparam logic [7:0]  FALL_END    = 8'd160;
    localparam logic [7:0]  RAMP_ROUND  = 8'd20;
    localparam logic [7:0]  RGB_ROUND   = 8'd120;

    // floor(y * R / 2^16) == floor(y / N) over the ranges used here
    localparam logic [12:0] RECIP_15    = 13'd4370;   // y < 3834
    localparam logic [13:0] RECIP_5     = 14'd13108;  // y < 2048

    // Hue ramp segment of one channel
    typedef enum logic [1:0] {
        SEG_RISE,
        SEG_FLAT,
        SEG_FALL,
        SEG_LOW
    } seg_t;

    // Load enables for the per-channel stages
    typedef struct packed {
        logic s3;
        logic s4;
        logic s5;
        logic s6;
    } stage_en_t;

    // x / 240 for x <= 61320: shift right by 4, then reciprocal multiply by 1/15
    function automatic logic [7:0] div240(input logic [15:0] x);
        logic [24:0] p;
        p = 25'(x[15:4]) * 25'(RECIP_15);
        return p[23:16];
    endfunction

    // x / 40 for x <= 9620: shift right by 3, then reciprocal multiply by 1/5
    function automatic logic [7:0] div40(input logic [13:0] x);
        logic [24:0] p;
        p = 25'(x[13:3]) * 25'(RECIP_5);
        return p[23:16];
    endfunction

endpackage

### sv/hsl240_chan.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hsl240_chan
// One color channel: hue ramp between the two levels, then rescale of the
// 0..240 level to 0..255 with rounding. Four register stages.
// ---------------------------------------------------------------------------
module hsl240_chan (
    input  logic                  clk,
    input  hsl240_pkg::stage_en_t en,
    input  logic [7:0]            hue_w,     // wrapped hue, 0..240
    input  logic [7:0]            light,     // clamped lightness
    input  logic [7:0]            high,      // high level
    output logic [7:0]            level
);
    import hsl240_pkg::*;

    // stage 3: segment, low level, ramp product
    logic [8:0]  lo_wide;
    logic [7:0]  lo_next;
    logic [7:0]  span;
    logic [5:0]  ramp_t;
    logic [7:0]  fall_t;
    logic [14:0] prod_wide;
    seg_t        seg_next;

    seg_t        seg_reg;
    logic [7:0]  lo_reg;
    logic [7:0]  hi_reg;
    logic [13:0] prod_reg;

    // stage 4: ramp value
    logic [7:0]  quot40;
    logic [7:0]  val_next;
    logic [7:0]  val_reg;

    // stage 5: rescale numerator
    logic [16:0] num_wide;
    logic [15:0] num_reg;

    // stage 6: rescaled level
    logic [7:0]  level_reg;

    always_comb
    begin
        lo_wide = {light, 1'b0} - {1'b0, high};
        lo_next = lo_wide[7:0];
        // high >= light, so hi - lo = 2 * (high - light) stays in 0..240
        span    = {7'(high - light), 1'b0};
        fall_t  = FALL_END - hue_w;
        if (hue_w < RISE_END)
        begin
            seg_next = SEG_RISE;
            ramp_t   = hue_w[5:0];
        end
        else if (hue_w < FLAT_END)
        begin
            seg_next = SEG_FLAT;
            ramp_t   = '0;
        end
        else if (hue_w < FALL_END)
        begin
            seg_next = SEG_FALL;
            ramp_t   = fall_t[5:0];
        end
        else
        begin
            seg_next = SEG_LOW;
            ramp_t   = '0;
        end
        prod_wide = 15'(span) * 15'(ramp_t) + 15'(RAMP_ROUND);
    end

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            seg_reg  <= seg_next;
            lo_reg   <= lo_next;
            hi_reg   <= high;
            prod_reg <= prod_wide[13:0];
        end
    end

    always_comb
    begin
        quot40 = div40(prod_reg);
        case (seg_reg)
            SEG_RISE: val_next = lo_reg + quot40;
            SEG_FLAT: val_next = hi_reg;
            SEG_FALL: val_next = lo_reg + quot40;
            default:  val_next = lo_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en.s4)
        begin
            val_reg <= val_next;
        end
    end

    // v * 255 + 120
    assign num_wide = {1'b0, val_reg, 8'b0} - 17'(val_reg) + 17'(RGB_ROUND);

    always_ff @(posedge clk)
    begin
        if (en.s5)
        begin
            num_reg <= num_wide[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s6)
        begin
            level_reg <= div240(num_reg);
        end
    end

    assign level = level_reg;

endmodule

### sv/hsl_to_rgb_240_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hsl_to_rgb_240_unit
// 240-scale hue/saturation/lightness to 8-bit RGB, six-stage pipeline.
// ---------------------------------------------------------------------------
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+------------------------------
//  input    | in        | in_valid / in_stall   | hue, saturation, lightness
//  output   | out       | out_valid / out_stall | red, green, blue
//
//  One request per clock cycle sustained while out_stall stays low; a request
//  passes the six register stages in order, the first loaded at the accepting
//  edge, and out_valid rises once it sits in stage 6.
//  Reset (rst_n low) clears only the stage valid bits; no warm-up pass.
//  Each stage loads when it is empty or the stage after it moves, so bubbles
//  are squeezed out and in_stall rises only when all six stages are full
//  and out_stall is high. A stalled result holds its value.
//
//  Stage 1: clamp inputs to 240, wrap red and blue hues, level and gray products
//  Stage 2: divide by 240 (reciprocal multiply), high level
//  Stage 3: low level, ramp segment and ramp product (per channel)
//  Stage 4: divide by 40, ramp value
//  Stage 5: v * 255 + 120
//  Stage 6: divide by 240; gray requests bypass with l * 255 / 240
// ---------------------------------------------------------------------------
module hsl_to_rgb_240_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] hue,
    input  logic [7:0] saturation,
    input  logic [7:0] lightness,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] red,
    output logic [7:0] green,
    output logic [7:0] blue
);
    import hsl240_pkg::*;

    // pipeline control
    logic [6:1]  vld_reg;
    logic [6:1]  vld_next;
    logic [6:1]  en;
    stage_en_t   chan_en;

    // stage 1
    logic [7:0]  h_c;
    logic [7:0]  s_c;
    logic [7:0]  l_c;
    logic [8:0]  hue_up;
    logic [7:0]  hr_next;
    logic [7:0]  hb_next;
    logic        le_next;
    logic [8:0]  mul_b;
    logic [17:0] lvl_prod;
    logic [15:0] gnum_next;

    logic [7:0]  hr1_reg;
    logic [7:0]  hg1_reg;
    logic [7:0]  hb1_reg;
    logic [7:0]  l1_reg;
    logic [7:0]  s1_reg;
    logic        gray1_reg;
    logic        le1_reg;
    logic [15:0] prod1_reg;
    logic [15:0] gnum1_reg;

    // stage 2
    logic [7:0]  quot_hi;
    logic [8:0]  sum_ls;
    logic [8:0]  hi_wide;
    logic [7:0]  hi_next;

    logic [7:0]  hr2_reg;
    logic [7:0]  hg2_reg;
    logic [7:0]  hb2_reg;
    logic [7:0]  l2_reg;
    logic [7:0]  hi2_reg;
    logic [7:0]  k2_reg;
    logic        gray2_reg;

    // gray level and flag riding along stages 3..6
    logic [7:0]  k_pipe_reg [3:6];
    logic        gray_pipe_reg [3:6];

    logic [7:0]  red_c;
    logic [7:0]  green_c;
    logic [7:0]  blue_c;

    // ---------------- pipeline control ----------------
    always_comb
    begin
        en[6] = !vld_reg[6] || !out_stall;
        en[5] = !vld_reg[5] || en[6];
        en[4] = !vld_reg[4] || en[5];
        en[3] = !vld_reg[3] || en[4];
        en[2] = !vld_reg[2] || en[3];
        en[1] = !vld_reg[1] || en[2];

        vld_next[1] = en[1] ? in_valid   : vld_reg[1];
        vld_next[2] = en[2] ? vld_reg[1] : vld_reg[2];
        vld_next[3] = en[3] ? vld_reg[2] : vld_reg[3];
        vld_next[4] = en[4] ? vld_reg[3] : vld_reg[4];
        vld_next[5] = en[5] ? vld_reg[4] : vld_reg[5];
        vld_next[6] = en[6] ? vld_reg[5] : vld_reg[6];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_stall  = !en[1];
    assign out_valid = vld_reg[6];

    assign chan_en.s3 = en[3];
    assign chan_en.s4 = en[4];
    assign chan_en.s5 = en[5];
    assign chan_en.s6 = en[6];

    // ---------------- stage 1 ----------------
    always_comb
    begin
        h_c = (hue        > SCALE_MAX) ? SCALE_MAX : hue;
        s_c = (saturation > SCALE_MAX) ? SCALE_MAX : saturation;
        l_c = (lightness  > SCALE_MAX) ? SCALE_MAX : lightness;

        // red at hue + 80, blue at hue - 80, each wrapped once into 0..240
        hue_up  = {1'b0, h_c} + {1'b0, HUE_THIRD};
        hr_next = (hue_up > {1'b0, SCALE_MAX}) ? 8'(hue_up - {1'b0, SCALE_MAX})
                                               : hue_up[7:0];
        hb_next = (h_c < HUE_THIRD) ? (h_c + HUE_COMP) : (h_c - HUE_THIRD);

        // l <= 120: l * (240 + s); else l * s; both get the +120 rounding
        le_next   = (l_c <= HALF_SCALE);
        mul_b     = le_next ? ({1'b0, SCALE_MAX} + {1'b0, s_c}) : {1'b0, s_c};
        lvl_prod  = 18'(l_c) * 18'(mul_b) + 18'(RGB_ROUND);
        gnum_next = {l_c, 8'b0} - 16'(l_c);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            hr1_reg   <= hr_next;
            hg1_reg   <= h_c;
            hb1_reg   <= hb_next;
            l1_reg    <= l_c;
            s1_reg    <= s_c;
            gray1_reg <= (s_c == '0);
            le1_reg   <= le_next;
            prod1_reg <= lvl_prod[15:0];
            gnum1_reg <= gnum_next;
        end
    end

    // ---------------- stage 2 ----------------
    always_comb
    begin
        quot_hi = div240(prod1_reg);
        sum_ls  = {1'b0, l1_reg} + {1'b0, s1_reg};
        hi_wide = sum_ls - {1'b0, quot_hi};
        hi_next = le1_reg ? quot_hi : hi_wide[7:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            hr2_reg   <= hr1_reg;
            hg2_reg   <= hg1_reg;
            hb2_reg   <= hb1_reg;
            l2_reg    <= l1_reg;
            hi2_reg   <= hi_next;
            k2_reg    <= div240(gnum1_reg);
            gray2_reg <= gray1_reg;
        end
    end

    // ---------------- gray bypass, stages 3..6 ----------------
    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            k_pipe_reg[3]    <= k2_reg;
            gray_pipe_reg[3] <= gray2_reg;
        end
        if (en[4])
        begin
            k_pipe_reg[4]    <= k_pipe_reg[3];
            gray_pipe_reg[4] <= gray_pipe_reg[3];
        end
        if (en[5])
        begin
            k_pipe_reg[5]    <= k_pipe_reg[4];
            gray_pipe_reg[5] <= gray_pipe_reg[4];
        end
        if (en[6])
        begin
            k_pipe_reg[6]    <= k_pipe_reg[5];
            gray_pipe_reg[6] <= gray_pipe_reg[5];
        end
    end

    // ---------------- channels, stages 3..6 ----------------
    hsl240_chan u_chan_red (
        .clk   (clk),
        .en    (chan_en),
        .hue_w (hr2_reg),
        .light (l2_reg),
        .high  (hi2_reg),
        .level (red_c)
    );

    hsl240_chan u_chan_green (
        .clk   (clk),
        .en    (chan_en),
        .hue_w (hg2_reg),
        .light (l2_reg),
        .high  (hi2_reg),
        .level (green_c)
    );

    hsl240_chan u_chan_blue (
        .clk   (clk),
        .en    (chan_en),
        .hue_w (hb2_reg),
        .light (l2_reg),
        .high  (hi2_reg),
        .level (blue_c)
    );

    assign red   = gray_pipe_reg[6] ? k_pipe_reg[6] : red_c;
    assign green = gray_pipe_reg[6] ? k_pipe_reg[6] : green_c;
    assign blue  = gray_pipe_reg[6] ? k_pipe_reg[6] : blue_c;

    // ---------------- checks ----------------
    // input side stalls only with every stage holding a request
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (vld_reg == '1 && out_stall))
        else $error("in_stall raised with a free stage");

    // an empty first stage always takes a request
    a_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
        !vld_reg[1] |-> !in_stall)
        else $error("empty first stage stalls input");

    // high level never below lightness for a colored request
    a_hi_order: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[2] && !gray2_reg) |-> (hi2_reg >= l2_reg && hi2_reg <= SCALE_MAX))
        else $error("high level out of order");

    // gray result carries one level on all channels
    a_gray_equal: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && gray_pipe_reg[6]) |-> (red == green && green == blue))
        else $error("gray result with unequal channels");

    // a request moving out of stage 5 lands in stage 6
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[5] && en[6]) |=> vld_reg[6])
        else $error("request lost between stages 5 and 6");

endmodule

### tb/hsl_to_rgb_240_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hsl_to_rgb_240_unit_tb
// Self-checking bench for the 240-scale HSL to RGB pipeline. A directed
// table covers the primaries, gray, white, black, the hue ramp breakpoints
// and inputs above 240. Random requests follow, first back to back on both
// sides, then with random idling and one long output hold-off. Every
// result is checked field by field against its hand-read color or the model.
// ---------------------------------------------------------------------------
module hsl_to_rgb_240_unit_tb;

    localparam int SCALE      = 240;
    localparam int FULL_BYTE  = 255;
    localparam int N_RANDOM   = 950;
    localparam int N_BURST    = 150;      // leading random requests with no idling
    localparam int HOLD_LEN   = 120;      // long output hold-off, in cycles
    localparam int DRAIN_WAIT = 12;       // pipeline is six deep
    localparam int CYCLE_MAX  = 200000;

    // One row of the directed table; known rows carry a hand-read result
    typedef struct packed {
        logic [7:0] h;
        logic [7:0] s;
        logic [7:0] l;
        bit         known;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } stim_row_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    localparam int N_DIR = 22;

    stim_row_t dir_rows [N_DIR] = '{
        // gray: lightness scaled by 255/240, truncated
        '{8'd0,   8'd0,   8'd0,   1'b1, 8'd0,   8'd0,   8'd0  },
        '{8'd0,   8'd0,   8'd240, 1'b1, 8'd255, 8'd255, 8'd255},
        '{8'd17,  8'd0,   8'd120, 1'b1, 8'd127, 8'd127, 8'd127},
        '{8'd255, 8'd0,   8'd255, 1'b1, 8'd255, 8'd255, 8'd255},
        // full saturation primaries and hue wrap
        '{8'd0,   8'd240, 8'd120, 1'b1, 8'd255, 8'd0,   8'd0  },
        '{8'd80,  8'd240, 8'd120, 1'b1, 8'd0,   8'd255, 8'd0  },
        '{8'd160, 8'd240, 8'd120, 1'b1, 8'd0,   8'd0,   8'd255},
        '{8'd240, 8'd240, 8'd120, 1'b1, 8'd255, 8'd0,   8'd0  },
        '{8'd255, 8'd255, 8'd120, 1'b1, 8'd255, 8'd0,   8'd0  },
        // white and black
        '{8'd0,   8'd240, 8'd240, 1'b1, 8'd255, 8'd255, 8'd255},
        '{8'd120, 8'd240, 8'd0,   1'b1, 8'd0,   8'd0,   8'd0  },
        '{8'd200, 8'd255, 8'd255, 1'b1, 8'd255, 8'd255, 8'd255},
        // ramp breakpoints and lightness around the midpoint, model-checked
        '{8'd39,  8'd200, 8'd100, 1'b0, 8'd0, 8'd0, 8'd0},
        '{8'd40,  8'd200, 8'd100, 1'b0, 8'd0, 8'd0, 8'd0},
        '{8'd119, 8'd200, 8'd100, 1'b0, 8'd0, 8'd0, 8'd0},
        '{8'd120, 8'd200, 8'd100, 1'b0, 8'd0, 8'd0, 8'd0},
        '{8'd159, 8'd200, 8'd100, 1'b0, 8'd0, 8'd0, 8'd0},
        '{8'd1,   8'd1,   8'd120, 1'b0, 8'd0, 8'd0, 8'd0},
        '{8'd79,  8'd77,  8'd121, 1'b0, 8'd0, 8'd0, 8'd0},
        '{8'd81,  8'd240, 8'd1,   1'b0, 8'd0, 8'd0, 8'd0},
        '{8'd241, 8'd241, 8'd239, 1'b0, 8'd0, 8'd0, 8'd0},
        '{8'd170, 8'd128, 8'd170, 1'b0, 8'd0, 8'd0, 8'd0}
    };

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] lightness;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    rgb_t pending_rgb [$];   // colors owed by the pipeline, oldest first
    int   error_count = 0;
    int   cycle_count = 0;
    bit   idle_on     = 1'b1;
    bit   hold_req    = 1'b0;

    hsl_to_rgb_240_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .hue        (hue),
        .saturation (saturation),
        .lightness  (lightness),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // -----------------------------------------------------------------------
    // Color model
    // -----------------------------------------------------------------------
    function automatic int clamp_scale(input logic [7:0] v);
        return (int'(v) > SCALE) ? SCALE : int'(v);
    endfunction

    // Piecewise hue ramp between the low and high levels, hue wrapped once
    function automatic int hue_ramp(input int lo, input int hi, input int h);
        int hw;
        hw = h;
        if (hw < 0)
            hw += SCALE;
        if (hw > SCALE)
            hw -= SCALE;
        if (hw < 40)
            return lo + ((hi - lo) * hw + 20) / 40;
        if (hw < 120)
            return hi;
        if (hw < 160)
            return lo + ((hi - lo) * (160 - hw) + 20) / 40;
        return lo;
    endfunction

    // 0..240 level to 0..255 byte, rounded
    function automatic logic [7:0] scale_to_byte(input int v);
        int c;
        c = (v * FULL_BYTE + 120) / SCALE;
        if (c < 0)
            c = 0;
        if (c > FULL_BYTE)
            c = FULL_BYTE;
        return 8'(c);
    endfunction

    function automatic rgb_t hsl_to_rgb_color(input logic [7:0] h_in,
                                              input logic [7:0] s_in,
                                              input logic [7:0] l_in);
        int   h;
        int   s;
        int   l;
        int   hi;
        int   lo;
        rgb_t c;
        h = clamp_scale(h_in);
        s = clamp_scale(s_in);
        l = clamp_scale(l_in);
        if (s == 0)
        begin
            c.r = 8'((l * FULL_BYTE) / SCALE);
            c.g = c.r;
            c.b = c.r;
            return c;
        end
        if (l <= 120)
            hi = (l * (SCALE + s) + 120) / SCALE;
        else
            hi = l + s - (l * s + 120) / SCALE;
        lo = 2 * l - hi;
        c.r = scale_to_byte(hue_ramp(lo, hi, h + 80));
        c.g = scale_to_byte(hue_ramp(lo, hi, h));
        c.b = scale_to_byte(hue_ramp(lo, hi, h - 80));
        return c;
    endfunction

    // -----------------------------------------------------------------------
    // Request side: optional gap, then hold the request until it is taken.
    // The expected color is queued at the edge that accepts the request.
    // -----------------------------------------------------------------------
    task automatic send_request(input logic [7:0] h, input logic [7:0] s,
                                input logic [7:0] l, input rgb_t want);
        int gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        hue        <= h;
        saturation <= s;
        lightness  <= l;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_rgb.push_back(want);
    endtask

    // -----------------------------------------------------------------------
    // Result side: random stall before each result; on request one long
    // hold-off so the pipeline fills and pushes back on the input.
    // -----------------------------------------------------------------------
    initial
    begin
        int wait_n;
        out_stall <= 1'b1;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_LEN) @(posedge clk);
                hold_req = 1'b0;
            end
            wait_n = idle_on ? $urandom_range(0, 4) : 0;
            if (wait_n > 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_n) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // Compare each taken result against the oldest owed color
    always @(posedge clk)
    begin
        rgb_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_rgb.size() == 0)
            begin
                $display("%0t: unexpected result r=%0d g=%0d b=%0d",
                         $time, red, green, blue);
                error_count++;
            end
            else
            begin
                want = pending_rgb.pop_front();
                if (red !== want.r)
                begin
                    $display("%0t: red mismatch, expected %0d, got %0d",
                             $time, want.r, red);
                    error_count++;
                end
                if (green !== want.g)
                begin
                    $display("%0t: green mismatch, expected %0d, got %0d",
                             $time, want.g, green);
                    error_count++;
                end
                if (blue !== want.b)
                begin
                    $display("%0t: blue mismatch, expected %0d, got %0d",
                             $time, want.b, blue);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_MAX)
            @(posedge clk);
        $display("Some tests failed");
        $finish;
    end

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial
    begin
        rgb_t       want;
        logic [7:0] h;
        logic [7:0] s;
        logic [7:0] l;
        int         pick;

        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        hue        <= 8'd0;
        saturation <= 8'd0;
        lightness  <= 8'd0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: hand-read colors where known, model elsewhere
        for (int i = 0; i < N_DIR; i++)
        begin
            if (dir_rows[i].known)
            begin
                want.r = dir_rows[i].r;
                want.g = dir_rows[i].g;
                want.b = dir_rows[i].b;
            end
            else
                want = hsl_to_rgb_color(dir_rows[i].h, dir_rows[i].s, dir_rows[i].l);
            send_request(dir_rows[i].h, dir_rows[i].s, dir_rows[i].l, want);
        end

        // Random part: a back-to-back burst, then idling and one long hold
        idle_on = 1'b0;
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == N_BURST)
            begin
                idle_on  = 1'b1;
                hold_req = 1'b1;
            end
            pick = $urandom_range(0, 99);
            h = 8'($urandom_range(0, SCALE));
            s = 8'($urandom_range(1, SCALE));
            l = 8'($urandom_range(0, SCALE));
            if (pick < 10)
                s = 8'd0;                               // gray
            else if (pick < 22)
            begin
                // any byte, including values above 240
                h = 8'($urandom_range(0, 255));
                s = 8'($urandom_range(0, 255));
                l = 8'($urandom_range(0, 255));
            end
            else if (pick < 35)
            begin
                // hue near a ramp breakpoint of some channel
                h = 8'(40 * $urandom_range(0, 6));
                if (h != 8'd0 && $urandom_range(0, 1))
                    h = h - 8'd1;
            end
            send_request(h, s, l, hsl_to_rgb_color(h, s, l));
        end
        in_valid <= 1'b0;

        while (pending_rgb.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
